>>> hw/rtl/lufmm_pkg.sv
// ----------------------------------------------------------------------------
// lufmm_pkg: shared types and constants of the largest-user flush manager
// Operation codes, result codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package lufmm_pkg;

	localparam int TOTAL_W = 44;
	localparam int OP_W    = 2;
	localparam int ID_W    = 4;
	localparam int CODE_W  = 3;

	localparam logic [TOTAL_W-1:0] LIMIT_RESET = 44'd268435456;

	typedef enum logic [OP_W-1:0] {
		OP_UPDATE = 2'd0,
		OP_UNREG  = 2'd1,
		OP_WRITE  = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	typedef enum logic [CODE_W-1:0] {
		CODE_OK         = 3'd0,
		CODE_FLUSH      = 3'd1,
		CODE_CANNOT     = 3'd2,
		CODE_NO_GAIN    = 3'd3,
		CODE_BUSY       = 3'd4,
		CODE_UNEXPECTED = 3'd5
	} code_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_SUB,
		ST_ADD,
		ST_GAIN,
		ST_LIMIT,
		ST_SCAN,
		ST_DECIDE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/largest_user_flush_memory_manager.sv
// ----------------------------------------------------------------------------
// largest_user_flush_memory_manager: per-client usage table with flush picks
// Tracks client usage and a running total; asks the largest client to flush.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per usage event:
//   op, client_id, usage_bytes. Output channel (out_valid/out_stall) returns
//   exactly one transaction per input: code, flush_client, total_usage.
//   Config channel (cfg_valid/cfg_ready) writes usage_limit; always ready,
//   write it only while the block is idle.
// Flow (one item at a time, in_stall high while an item is in work): busy,
//   unexpected flush done, out-of-range update or unregister go straight
//   to the result, an out-of-range write to the limit compare; the rest
//   read the entry and drop its old usage from the total; all but unregister
//   then add the new one. A flush done checks its gain, and a write or flush
//   done compares the total with the limit; a flush pick adds a scan of the
//   table through its single read port and the shared adder.
// Reset: clears the valid marks, the total, the pending-flush state and the
//   limit (to its reset value). The usage memory is not cleared; an entry
//   only ever counts once its valid mark is set.
// Receiver stall: the finished result is held in the output register; the
//   next item is still accepted and worked on, and waits in its final state
//   until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_user_flush_memory_manager #(
	parameter int MAX_CLIENTS = 16,
	parameter int USAGE_BITS  = 40
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [lufmm_pkg::OP_W-1:0]    op,
	input  wire logic [lufmm_pkg::ID_W-1:0]    client_id,
	input  wire logic [USAGE_BITS-1:0]         usage_bytes,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [lufmm_pkg::CODE_W-1:0]  code,
	output logic      [lufmm_pkg::ID_W-1:0]    flush_client,
	output logic      [lufmm_pkg::TOTAL_W-1:0] total_usage,
	// configuration channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lufmm_pkg::TOTAL_W-1:0] cfg_data
);
	import lufmm_pkg::*;

	localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
	localparam int ALU_W = (USAGE_BITS > TOTAL_W) ? USAGE_BITS : TOTAL_W;

	// usage memory, one entry per client
	logic [USAGE_BITS-1:0] mem [MAX_CLIENTS];
	logic [USAGE_BITS-1:0] rdata_q;

	state_t                state_q, state_d;
	logic [MAX_CLIENTS-1:0] valid_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [TOTAL_W-1:0]    limit_q;
	logic                  await_q;
	logic [IDX_W-1:0]      flush_q;
	logic [USAGE_BITS-1:0] ubf_q;

	// current item
	op_t                   op_q;
	logic [IDX_W-1:0]      tgt_q;
	logic [USAGE_BITS-1:0] bytes_q;
	code_t                 code_q;
	logic [ID_W-1:0]       who_q;

	// scan of the table
	logic [CNT_W-1:0]      scan_cnt_q;
	logic                  cmp_live_q;
	logic [IDX_W-1:0]      cmp_idx_q;
	logic [USAGE_BITS-1:0] best_q;
	logic [IDX_W-1:0]      best_idx_q;

	// output register
	logic                  out_valid_q;
	code_t                 out_code_q;
	logic [ID_W-1:0]       out_who_q;
	logic [TOTAL_W-1:0]    out_total_q;

	logic                  in_take;
	logic                  out_free;
	logic                  id_in_range;
	logic                  scan_end;
	logic                  scan_rd;
	logic                  scan_better;
	logic [ALU_W-1:0]      alu_a, alu_b, alu_res;
	logic                  alu_sub, alu_nb;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_take     = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign id_in_range = 9'(client_id) < 9'(MAX_CLIENTS);
	assign scan_end    = (scan_cnt_q == CNT_W'(MAX_CLIENTS));
	assign scan_rd     = (scan_cnt_q < CNT_W'(MAX_CLIENTS));
	// borrow on best - entry means the entry is strictly larger
	assign scan_better = cmp_live_q && valid_q[cmp_idx_q] && !alu_nb;

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign code         = out_code_q;
	assign flush_client = out_who_q;
	assign total_usage  = out_total_q;

	lufmm_alu #(.W(ALU_W)) u_alu (
		.a         (alu_a),
		.b         (alu_b),
		.sub       (alu_sub),
		.res       (alu_res),
		.no_borrow (alu_nb)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					if (op_t'(op) == OP_FLUSH) begin
						state_d = await_q ? ST_READ : ST_DONE;
					end else if (await_q) begin
						state_d = ST_DONE;
					end else if (id_in_range) begin
						state_d = ST_READ;
					end else if (op_t'(op) == OP_WRITE) begin
						state_d = ST_LIMIT;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_READ:   state_d = ST_SUB;
			ST_SUB:    state_d = (op_q == OP_UNREG) ? ST_DONE : ST_ADD;
			ST_ADD: begin
				unique case (op_q)
					OP_WRITE: state_d = ST_LIMIT;
					OP_FLUSH: state_d = ST_GAIN;
					default:  state_d = ST_DONE;
				endcase
			end
			ST_GAIN:   state_d = alu_nb ? ST_DONE : ST_LIMIT;
			ST_LIMIT:  state_d = alu_nb ? ST_SCAN : ST_DONE;
			ST_SCAN:   state_d = scan_end ? ST_DECIDE : ST_SCAN;
			ST_DECIDE: state_d = ST_DONE;
			ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// shared adder operands
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_SUB: begin
				alu_a   = ALU_W'(total_q);
				alu_b   = ALU_W'(rdata_q);
				alu_sub = 1'b1;
			end
			ST_ADD: begin
				alu_a   = ALU_W'(total_q);
				alu_b   = ALU_W'(bytes_q);
			end
			ST_GAIN: begin
				alu_a   = ALU_W'(bytes_q);
				alu_b   = ALU_W'(ubf_q);
				alu_sub = 1'b1;
			end
			ST_LIMIT: begin
				alu_a   = ALU_W'(total_q);
				alu_b   = ALU_W'(limit_q);
				alu_sub = 1'b1;
			end
			ST_SCAN: begin
				alu_a   = ALU_W'(best_q);
				alu_b   = ALU_W'(rdata_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
			end
		endcase
	end

	// usage memory: written when an item adds its usage, read for the target and during the scan
	always_ff @(posedge clk) begin
		if (state_q == ST_ADD) begin
			mem[tgt_q] <= bytes_q;
		end
		if (state_q == ST_READ) begin
			rdata_q <= mem[tgt_q];
		end else if (state_q == ST_SCAN && scan_rd) begin
			rdata_q <= mem[scan_cnt_q[IDX_W-1:0]];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			total_q     <= '0;
			limit_q     <= LIMIT_RESET;
			await_q     <= 1'b0;
			flush_q     <= '0;
			ubf_q       <= '0;
			scan_cnt_q  <= '0;
			cmp_live_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (in_take && op_t'(op) == OP_FLUSH) begin
				await_q <= 1'b0;
			end
			unique case (state_q)
				ST_SUB: begin
					// drop the old usage from the total
					if (valid_q[tgt_q]) begin
						total_q <= alu_res[TOTAL_W-1:0];
					end
					if (op_q == OP_UNREG) begin
						valid_q[tgt_q] <= 1'b0;
					end
				end
				ST_ADD: begin
					total_q        <= alu_res[TOTAL_W-1:0];
					valid_q[tgt_q] <= 1'b1;
				end
				ST_LIMIT: begin
					scan_cnt_q <= '0;
					cmp_live_q <= 1'b0;
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					cmp_live_q <= scan_rd;
				end
				ST_DECIDE: begin
					if (best_q != '0) begin
						await_q <= 1'b1;
						flush_q <= best_idx_q;
						ubf_q   <= best_q;
					end
				end
				default: begin
				end
			endcase
			// load a finished result, or drop the one the receiver took
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload and scan results
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					op_q    <= op_t'(op);
					tgt_q   <= (op_t'(op) == OP_FLUSH) ? flush_q : IDX_W'(client_id);
					bytes_q <= usage_bytes;
					who_q   <= '0;
					if (op_t'(op) == OP_FLUSH) begin
						code_q <= await_q ? CODE_OK : CODE_UNEXPECTED;
					end else begin
						code_q <= await_q ? CODE_BUSY : CODE_OK;
					end
				end
			end
			ST_GAIN: begin
				if (alu_nb) begin
					code_q <= CODE_NO_GAIN;
				end
			end
			ST_LIMIT: begin
				best_q     <= '0;
				best_idx_q <= '0;
			end
			ST_SCAN: begin
				cmp_idx_q <= scan_cnt_q[IDX_W-1:0];
				if (scan_better) begin
					best_q     <= rdata_q;
					best_idx_q <= cmp_idx_q;
				end
			end
			ST_DECIDE: begin
				if (best_q == '0) begin
					code_q <= CODE_CANNOT;
					who_q  <= '0;
				end else begin
					code_q <= CODE_FLUSH;
					who_q  <= ID_W'(best_idx_q);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_code_q  <= code_q;
					out_who_q   <= who_q;
					out_total_q <= total_q;
				end
			end
			default: begin
			end
		endcase
	end

	// the client being waited on always holds a valid entry
	a_await_valid: assert property (@(posedge clk) disable iff (!arst_n)
		await_q |-> valid_q[flush_q])
		else $error("awaited flush client is not valid");

	// a flush request leaves the block waiting for that flush
	a_flush_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && code_q == CODE_FLUSH) |-> await_q)
		else $error("flush request without pending flush");

	// an empty scan result never turns into a flush request
	a_zero_cannot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && best_q == '0) |=> (code_q == CODE_CANNOT && !await_q))
		else $error("zero largest usage not reported as cannot release");

	// the scan stops after the last entry
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_cnt_q <= CNT_W'(MAX_CLIENTS)))
		else $error("scan counter ran past the table");

endmodule

`default_nettype wire

>>> hw/rtl/lufmm_alu.sv
// ----------------------------------------------------------------------------
// lufmm_alu: shared add/subtract unit
// One adder used for total updates and for every magnitude compare.
// ----------------------------------------------------------------------------
`default_nettype none

module lufmm_alu #(
	parameter int W = 44
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         sub,
	output logic      [W-1:0] res,
	output logic              no_borrow
);
	logic [W:0] sum;

	// subtract as a plus inverted b plus one; carry out set means a >= b
	assign sum       = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);
	assign res       = sum[W-1:0];
	assign no_borrow = sum[W];

endmodule

`default_nettype wire

>>> dv/tb_largest_user_flush_memory_manager.sv
// ----------------------------------------------------------------------------
// tb_largest_user_flush_memory_manager: self-checking bench of the flush manager
// Drives usage events through the stall channel and predicts every result
// with an in-bench copy of the usage table. Checks each result field by field
// over several usage_limit settings, with random gaps and stalls on both
// sides.
// ----------------------------------------------------------------------------
module tb_largest_user_flush_memory_manager;
	timeunit 1ns;
	timeprecision 1ps;

	import lufmm_pkg::*;

	localparam int CLIENTS     = 16;
	localparam int USAGE_W     = 40;
	localparam int PHASE_ITEMS = 200;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [USAGE_W-1:0] USAGE_MAX = '1;

	// one usage event as it goes into the block
	typedef struct packed {
		op_t                kind;
		logic [ID_W-1:0]    id;
		logic [USAGE_W-1:0] bytes;
	} usage_event_t;

	// one predicted result of the block
	typedef struct packed {
		code_t              code;
		logic [ID_W-1:0]    who;
		logic [TOTAL_W-1:0] total;
	} verdict_t;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     op          = '0;
	logic [ID_W-1:0]     client_id   = '0;
	logic [USAGE_W-1:0]  usage_bytes = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [CODE_W-1:0]   code;
	logic [ID_W-1:0]     flush_client;
	logic [TOTAL_W-1:0]  total_usage;
	logic                cfg_valid   = 1'b0;
	logic                cfg_ready;
	logic [TOTAL_W-1:0]  cfg_data    = '0;

	largest_user_flush_memory_manager #(
		.MAX_CLIENTS(CLIENTS),
		.USAGE_BITS (USAGE_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.client_id   (client_id),
		.usage_bytes (usage_bytes),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code        (code),
		.flush_client(flush_client),
		.total_usage (total_usage),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Shadow of the block: usage table, running total and flush bookkeeping.
	// Updated only when a transaction is accepted, so it always matches the
	// block as of the last accepted input.
	// ------------------------------------------------------------------------
	logic [USAGE_W-1:0] usage_tbl [CLIENTS];
	bit                 valid_tbl [CLIENTS];
	logic [TOTAL_W-1:0] total_now;
	logic [TOTAL_W-1:0] limit_now;
	bit                 flush_pending;
	logic [ID_W-1:0]    flush_victim;
	logic [USAGE_W-1:0] victim_before;

	usage_event_t events_queued [$];   // waiting for the driver
	verdict_t     verdicts_due [$];    // predicted, result not yet seen
	usage_event_t next_event;
	verdict_t     seen_want;

	int  events_pushed   = 0;
	int  events_accepted = 0;
	int  results_checked = 0;
	int  errors          = 0;
	int  limit_writes    = 0;
	int  phase_items     = 0;
	int  cycle_count     = 0;
	int  code_tally [8];
	int  send_wait       = 0;
	int  recv_wait       = 0;
	bit  send_calm       = 1'b0;
	bit  recv_calm       = 1'b0;
	bit  in_hold;

	// Register or refresh one client; the total wraps at its own width.
	function automatic void store_usage(input logic [ID_W-1:0] idx,
			input logic [USAGE_W-1:0] bytes);
		if (valid_tbl[idx]) begin
			total_now = total_now - usage_tbl[idx] + bytes;
		end else begin
			valid_tbl[idx] = 1'b1;
			total_now = total_now + bytes;
		end
		usage_tbl[idx] = bytes;
	endfunction

	// At or over the limit: pick the largest valid client, lowest index on a tie.
	function automatic verdict_t limit_verdict();
		verdict_t           r;
		logic [USAGE_W-1:0] top;
		logic [ID_W-1:0]    top_idx;
		r.code  = CODE_OK;
		r.who   = '0;
		top     = '0;
		top_idx = '0;
		if (total_now >= limit_now) begin
			for (int i = 0; i < CLIENTS; i++) begin
				if (valid_tbl[i] && usage_tbl[i] > top) begin
					top     = usage_tbl[i];
					top_idx = 4'(i);
				end
			end
			if (top == '0) begin
				r.code = CODE_CANNOT;
			end else begin
				flush_pending = 1'b1;
				flush_victim  = top_idx;
				victim_before = top;
				r.code        = CODE_FLUSH;
				r.who         = top_idx;
			end
		end
		r.total = total_now;
		return r;
	endfunction

	// Advance the shadow by one accepted event and return the result it owes.
	function automatic verdict_t account_event(input op_t kind,
			input logic [ID_W-1:0] id, input logic [USAGE_W-1:0] bytes);
		verdict_t r;
		r.code = CODE_OK;
		r.who  = '0;
		if (kind == OP_FLUSH) begin
			if (!flush_pending) begin
				r.code = CODE_UNEXPECTED;
			end else begin
				// client_id is ignored: the result belongs to the remembered client
				flush_pending = 1'b0;
				store_usage(flush_victim, bytes);
				if (bytes >= victim_before) begin
					r.code = CODE_NO_GAIN;
				end else begin
					r = limit_verdict();
				end
			end
		end else if (flush_pending) begin
			r.code = CODE_BUSY;
		end else begin
			case (kind)
				OP_UPDATE: begin
					store_usage(id, bytes);
				end
				OP_UNREG: begin
					if (valid_tbl[id]) begin
						total_now     = total_now - usage_tbl[id];
						valid_tbl[id] = 1'b0;
						usage_tbl[id] = '0;
					end
				end
				default: begin
					store_usage(id, bytes);
					r = limit_verdict();
				end
			endcase
		end
		r.total = total_now;
		return r;
	endfunction

	function automatic int draw_pause(input bit calm);
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	// Usage up to a quarter of the limit, so a few clients together reach it;
	// now and then zero, all ones or a fully random value.
	function automatic logic [USAGE_W-1:0] draw_usage();
		logic [63:0] r;
		logic [63:0] span;
		logic [63:0] pick;
		r    = {$urandom, $urandom};
		span = 64'(limit_now >> 2);
		if (span == 0) span = 1;
		if (span > 64'(USAGE_MAX)) span = 64'(USAGE_MAX);
		pick = r % (span + 1);
		case ($urandom_range(0, 9))
			0: return r[USAGE_W-1:0];
			1: return '0;
			2: return USAGE_MAX;
			default: return pick[USAGE_W-1:0];
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Clock, and the cycle guard that ends a hung run.
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycle_count, verdicts_due.size());
			$display("tb_largest_user_flush_memory_manager: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Driver: offer the next queued event after a random pause. Predict the
	// result at the edge that accepts the transaction, then hold or advance
	// the payload; a stalled payload never moves.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			send_wait = 0;
		end else begin
			if (in_valid && !in_stall) begin
				verdicts_due.push_back(account_event(op_t'(op), client_id, usage_bytes));
				events_accepted++;
				// switch now and then between gappy and back-to-back stretches
				if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
				send_wait = draw_pause(send_calm);
				in_hold   = 1'b0;
			end else begin
				in_hold = in_valid;
			end
			if (!in_hold) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (events_queued.size() != 0) begin
					next_event  = events_queued.pop_front();
					op          <= next_event.kind;
					client_id   <= next_event.id;
					usage_bytes <= next_event.bytes;
					in_valid    <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each accepted result against the oldest prediction, then
	// draw how long to stall before taking the next one.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (!$isunknown(code)) code_tally[code]++;
				if (verdicts_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result with nothing due: code %0d client %0d total %0d",
							code, flush_client, total_usage);
				end else begin
					seen_want = verdicts_due.pop_front();
					if (code !== seen_want.code || flush_client !== seen_want.who ||
							total_usage !== seen_want.total) begin
						errors++;
						if (errors <= 10)
							$display("mismatch at result %0d: want code %0d client %0d total %0d, %s %0d %0d %0d",
								results_checked, seen_want.code, seen_want.who,
								seen_want.total, "got", code, flush_client, total_usage);
					end
				end
				if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
				recv_wait = draw_pause(recv_calm);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_stall <= (recv_wait > 0);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic queue_event(input op_t kind, input logic [ID_W-1:0] id,
			input logic [USAGE_W-1:0] bytes);
		usage_event_t ev;
		ev.kind  = kind;
		ev.id    = id;
		ev.bytes = bytes;
		events_queued.push_back(ev);
		events_pushed++;
	endtask

	// Hold off until every queued transaction is in and every result is out;
	// the block is idle afterwards since every event owes exactly one result.
	task automatic settle();
		while (events_accepted != events_pushed || verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [TOTAL_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = value;
		limit_writes++;
	endtask

	// A burst of updates, unregisters and writes (with a flush result now and
	// then), closed by a completed write. While a flush is owed, answer it:
	// mostly with a gain, sometimes with none, at times after busy noise.
	task automatic run_round();
		int                 burst;
		logic [63:0]        r;
		logic [USAGE_W-1:0] b;
		burst = $urandom_range(0, 6);
		repeat (burst) begin
			case ($urandom_range(0, 19))
				0: queue_event(OP_FLUSH, 4'($urandom_range(0, 15)), draw_usage());
				1, 2: begin
					queue_event(OP_WRITE, 4'($urandom_range(0, 15)), draw_usage());
					phase_items++;
				end
				3, 4, 5, 6: begin
					queue_event(OP_UNREG, 4'($urandom_range(0, 15)), draw_usage());
					phase_items++;
				end
				default: begin
					queue_event(OP_UPDATE, 4'($urandom_range(0, 15)), draw_usage());
					phase_items++;
				end
			endcase
		end
		queue_event(OP_WRITE, 4'($urandom_range(0, 15)), draw_usage());
		phase_items++;
		settle();
		while (flush_pending) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2))
					queue_event(op_t'($urandom_range(0, 2)), 4'($urandom_range(0, 15)),
						draw_usage());
			r = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0: b = (victim_before == USAGE_MAX) ? victim_before :
					victim_before + USAGE_W'($urandom_range(0, 1));
				1, 2: b = '0;
				default: b = USAGE_W'(r % 64'(victim_before));
			endcase
			queue_event(OP_FLUSH, 4'($urandom_range(0, 15)), b);
			phase_items++;
			settle();
		end
	endtask

	initial begin
		logic [TOTAL_W-1:0] lim;
		for (int i = 0; i < CLIENTS; i++) begin
			usage_tbl[i] = '0;
			valid_tbl[i] = 1'b0;
		end
		for (int i = 0; i < 8; i++) code_tally[i] = 0;
		total_now     = '0;
		limit_now     = LIMIT_RESET;
		flush_pending = 1'b0;
		flush_victim  = '0;
		victim_before = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pass at the reset limit of 2^28. A client index is always in
		// range with 16 clients, and "cannot release" needs the total to reach the
		// limit with every usage zero, which no limit of at least one allows.
		queue_event(OP_FLUSH,  4'd5,  40'd0);                 // flush result, none asked
		queue_event(OP_UNREG,  4'd3,  USAGE_MAX);             // drop a client never seen
		queue_event(OP_UPDATE, 4'd0,  USAGE_MAX);             // largest usage
		queue_event(OP_UNREG,  4'd0,  40'd0);                 // drop it again
		queue_event(OP_UPDATE, 4'd15, 40'd0);                 // valid with zero usage
		queue_event(OP_WRITE,  4'd7,  40'd100);               // total below the limit
		queue_event(OP_UPDATE, 4'd2,  40'd1 << 27);
		queue_event(OP_UPDATE, 4'd9,  40'd1 << 27);           // tie with client 2
		queue_event(OP_WRITE,  4'd7,  40'd100);               // flush request, lower index wins
		queue_event(OP_UPDATE, 4'd1,  40'd5);                 // busy
		queue_event(OP_UNREG,  4'd2,  40'd0);                 // busy
		queue_event(OP_WRITE,  4'd4,  40'd1);                 // busy
		queue_event(OP_FLUSH,  4'd11, 40'd1 << 27);           // no gain
		queue_event(OP_WRITE,  4'd7,  40'd200);               // ask client 2 again
		queue_event(OP_FLUSH,  4'd0,  40'd1 << 26);           // gain, back under the limit
		queue_event(OP_UPDATE, 4'd5,  40'd1 << 28);
		queue_event(OP_WRITE,  4'd6,  40'd0);                 // ask client 5
		queue_event(OP_FLUSH,  4'd5,  (40'd1 << 28) - 40'd1); // gain, still over: ask again
		queue_event(OP_FLUSH,  4'd5,  40'd0);                 // gain, under the limit
		queue_event(OP_WRITE,  4'd8,  USAGE_MAX);             // ask client 8
		queue_event(OP_FLUSH,  4'd8,  USAGE_MAX);             // equal usage is no gain
		queue_event(OP_WRITE,  4'd3,  40'd0);                 // ask client 8 again
		queue_event(OP_FLUSH,  4'd14, 40'd0);
		queue_event(OP_UNREG,  4'd8,  40'd0);                 // drop a valid zero-usage client
		settle();

		// Random phases, each under its own limit: the smallest, the largest,
		// a wide random one, a small one, the reset value and a power of two.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim = 44'd1;
				1: lim = '1;
				2: begin
					lim = TOTAL_W'({$urandom, $urandom});
					if (lim == '0) lim = 44'd1;
				end
				3: lim = TOTAL_W'($urandom_range(1, 1 << 24));
				4: lim = LIMIT_RESET;
				default: lim = 44'd1 << $urandom_range(30, 40);
			endcase
			write_limit(lim);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) run_round();
		end

		settle();
		// let any stray result surface before the verdict
		repeat (60) @(posedge clk);
		if (verdicts_due.size() != 0) errors++;

		$display("covered %0d transactions in, %0d results checked, %0d limit settings",
			events_accepted, results_checked, limit_writes);
		$display("flush requests %0d, no gain %0d, busy %0d, stray flush results %0d",
			code_tally[CODE_FLUSH], code_tally[CODE_NO_GAIN], code_tally[CODE_BUSY],
			code_tally[CODE_UNEXPECTED]);
		if (errors == 0) begin
			$display("tb_largest_user_flush_memory_manager: PASS");
		end else begin
			$display("%0d mismatched or stray results", errors);
			$display("tb_largest_user_flush_memory_manager: FAIL");
		end
		$finish;
	end

endmodule
